// ===== rtl/utc_pkg.sv =====
// ----------------------------------------------------------------------------
// utc_pkg
// shared codes, field widths and the walk stack entry type for the
// undirected tree check
// ----------------------------------------------------------------------------
package utc_pkg;

  // payload field widths
  localparam int NODE_W    = 7;
  localparam int COUNT_W   = 7;
  localparam int VERDICT_W = 2;
  // scan position runs one past the last node, so it needs one more bit
  localparam int SCAN_W    = NODE_W + 1;

  // opcodes
  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_EVALUATE = 1'b1;

  // verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_TREE  = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_SPLIT = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_CYCLE = 2'd2;

  // register index of node_count
  localparam logic REG_NODE_COUNT = 1'b0;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [SCAN_W-1:0] scan;
  } stack_entry_t;

endpackage

// ===== rtl/utc_ram.sv =====
// ----------------------------------------------------------------------------
// utc_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module utc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/undirected_tree_check.sv =====
// ----------------------------------------------------------------------------
// undirected_tree_check
// loads undirected edges into a symmetric adjacency bit matrix and, on an
// evaluate item, walks it depth first from node 1 to tell tree, split graph
// or cycle
// ----------------------------------------------------------------------------
//
//  channel   signals                                   direction
//  --------  ----------------------------------------  ---------
//  input     in_valid, in_stall, opcode, first_node,   in
//            second_node
//  output    out_valid, out_stall, verdict,            out
//            visited_count
//  config    psel, penable, pwrite, paddr, pwdata,     in / out
//            prdata, pready (node_count at 0x0)
//
// an edge transfer does a read-modify-write of both matrix rows through the
// single write port of the row ram, in S_EDGE_A and then S_EDGE_B; a self-loop
// ends after S_EDGE_A and an edge naming a bad node is dropped in S_IDLE
// an evaluate loads the row of the stack top (S_LOAD), tests its bits in S_SCAN,
// takes each edge found in S_TAKE and returns from each pop via S_POP and S_LOAD
// reset clears all control state; matrix rows are marked empty by per-row
// valid flags, so no clearing pass is needed
// the finished result sits in an output register, so edges are taken while
// it waits; a second evaluate holds in its last state until the slot frees
//
module undirected_tree_check import utc_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  // input items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 opcode,
  input  logic [NODE_W-1:0]    first_node,
  input  logic [NODE_W-1:0]    second_node,
  // result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VERDICT_W-1:0] verdict,
  output logic [COUNT_W-1:0]   visited_count,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int NIW = $clog2(MAX_NODES);
  localparam int DW  = $clog2(MAX_NODES + 1);
  // largest node count that both the register and the matrix can hold
  localparam int CAP = (MAX_NODES > 127) ? 127 : MAX_NODES;
  localparam int SEW = $bits(stack_entry_t);

  // state codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EDGE_A = 3'd1;  // write first row, read second
  localparam logic [2:0] S_EDGE_B = 3'd2;  // write second row
  localparam logic [2:0] S_LOAD   = 3'd3;  // load row of stack top
  localparam logic [2:0] S_SCAN   = 3'd4;  // test one neighbor bit
  localparam logic [2:0] S_TAKE   = 3'd5;  // take edge, maybe push
  localparam logic [2:0] S_POP    = 3'd6;  // new top back from stack ram
  localparam logic [2:0] S_FINISH = 3'd7;  // post result, clear graph

  localparam logic [MAX_NODES-1:0] ONE_HOT = {{(MAX_NODES-1){1'b0}}, 1'b1};

  // registers
  logic [2:0]           state;
  logic [NODE_W-1:0]    node_count;
  logic [NODE_W-1:0]    edge_a;
  logic [NODE_W-1:0]    edge_b;
  logic [NODE_W-1:0]    top_node;
  logic [SCAN_W-1:0]    top_scan;
  logic [NODE_W-1:0]    hit_node;
  logic [DW-1:0]        depth;
  logic [MAX_NODES-1:0] cur_row;
  logic [MAX_NODES-1:0] row_valid;
  logic [MAX_NODES-1:0] visited;
  logic                 cycle_seen;
  logic [COUNT_W-1:0]   visit_cnt;
  logic                 rd_valid;

  // row ram ports
  logic                 row_we;
  logic [NIW-1:0]       row_waddr;
  logic [MAX_NODES-1:0] row_wdata;
  logic [NIW-1:0]       row_raddr;
  logic [MAX_NODES-1:0] row_rdata;
  logic [MAX_NODES-1:0] row_q;

  // stack ram ports
  logic                 stk_we;
  logic [NIW-1:0]       stk_waddr;
  stack_entry_t         stk_wdata;
  logic [NIW-1:0]       stk_raddr;
  logic [SEW-1:0]       stk_rdata;
  stack_entry_t         stk_top;

  logic [NODE_W-1:0]    n_eff;
  logic                 in_xfer;
  logic                 edge_ok;
  logic [NIW-1:0]       a_idx;
  logic [NIW-1:0]       b_idx;
  logic [NIW-1:0]       node_idx;
  logic [NIW-1:0]       scan_idx;
  logic [NIW-1:0]       hit_idx;
  logic                 scan_done;
  logic                 out_free;
  logic                 cfg_wr;

  // node count saturated to what the matrix holds
  assign n_eff = (node_count > NODE_W'(CAP)) ? NODE_W'(CAP) : node_count;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign edge_ok  = (first_node != '0) && (second_node != '0) &&
                    (first_node <= n_eff) && (second_node <= n_eff);

  assign a_idx     = NIW'(edge_a - NODE_W'(1));
  assign b_idx     = NIW'(edge_b - NODE_W'(1));
  assign node_idx  = NIW'(top_node - NODE_W'(1));
  assign scan_idx  = NIW'(top_scan - SCAN_W'(1));
  assign hit_idx   = NIW'(hit_node - NODE_W'(1));
  assign scan_done = (top_scan > {1'b0, n_eff});
  assign out_free  = !out_valid || !out_stall;

  // a row never written since the last clear reads as empty
  assign row_q   = rd_valid ? row_rdata : '0;
  assign stk_top = stk_rdata;

  // configuration port, always ready
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT);
  assign prdata = (paddr[2] == REG_NODE_COUNT) ? {{(32-NODE_W){1'b0}}, node_count} : '0;

  // ram address and write steering
  always_comb begin
    row_we    = 1'b0;
    row_waddr = a_idx;
    row_wdata = row_q;
    row_raddr = '0;
    stk_we    = 1'b0;
    stk_waddr = NIW'(depth - DW'(1));
    stk_wdata = '{node: top_node, scan: top_scan};
    stk_raddr = NIW'(depth - DW'(2));
    case (state)
      S_IDLE: begin
        // node 1 for an evaluate, the first end for an edge
        if (opcode == OP_ADD_EDGE) begin
          row_raddr = NIW'(first_node - NODE_W'(1));
        end
      end
      S_EDGE_A: begin
        row_we    = 1'b1;
        row_waddr = a_idx;
        row_wdata = row_q | (ONE_HOT << b_idx);
        row_raddr = b_idx;
      end
      S_EDGE_B: begin
        row_we    = 1'b1;
        row_waddr = b_idx;
        row_wdata = row_q | (ONE_HOT << a_idx);
      end
      S_SCAN: begin
        row_raddr = scan_idx;
      end
      S_TAKE: begin
        // drop the reverse copy so the edge is used once
        row_we    = 1'b1;
        row_waddr = hit_idx;
        row_wdata = row_q & ~(ONE_HOT << node_idx);
        stk_we    = !visited[hit_idx];
      end
      S_POP: begin
        row_raddr = NIW'(stk_top.node - NODE_W'(1));
      end
      default: begin
      end
    endcase
  end

  utc_ram #(
    .WIDTH(MAX_NODES),
    .DEPTH(MAX_NODES)
  ) u_row_ram (
    .clk  (clk),
    .we   (row_we),
    .waddr(row_waddr),
    .wdata(row_wdata),
    .raddr(row_raddr),
    .rdata(row_rdata)
  );

  utc_ram #(
    .WIDTH(SEW),
    .DEPTH(MAX_NODES)
  ) u_stack_ram (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

  // row valid flag travels with the registered read data
  always_ff @(posedge clk) begin
    rd_valid <= row_valid[row_raddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      edge_a <= first_node;
      edge_b <= second_node;
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= NODE_W'(1);
      depth      <= '0;
      row_valid  <= '0;
      visited    <= '0;
      cycle_seen <= 1'b0;
      visit_cnt  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        node_count <= pwdata[NODE_W-1:0];
      end
      // a new result replaces the one leaving this cycle
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (opcode == OP_EVALUATE) begin
              if (n_eff == '0) begin
                // nothing to walk
                visit_cnt <= '0;
                state     <= S_FINISH;
              end else begin
                visited[0] <= 1'b1;
                visit_cnt  <= COUNT_W'(1);
                top_node   <= NODE_W'(1);
                top_scan   <= SCAN_W'(1);
                depth      <= DW'(1);
                state      <= S_LOAD;
              end
            end else if (edge_ok) begin
              state <= S_EDGE_A;
            end
          end
        end

        S_EDGE_A: begin
          row_valid[a_idx] <= 1'b1;
          // a self-loop lands in one row
          state <= (edge_a == edge_b) ? S_IDLE : S_EDGE_B;
        end

        S_EDGE_B: begin
          row_valid[b_idx] <= 1'b1;
          state            <= S_IDLE;
        end

        S_LOAD: begin
          cur_row <= row_q;
          state   <= S_SCAN;
        end

        S_SCAN: begin
          if (scan_done) begin
            // node finished, drop it
            depth <= depth - DW'(1);
            state <= (depth == DW'(1)) ? S_FINISH : S_POP;
          end else begin
            top_scan <= top_scan + SCAN_W'(1);
            if (cur_row[scan_idx]) begin
              hit_node <= NODE_W'(top_scan);
              state    <= S_TAKE;
            end
          end
        end

        S_TAKE: begin
          row_valid[hit_idx] <= 1'b1;
          if (!visited[hit_idx]) begin
            // descend: old top went to the stack ram this cycle
            visited[hit_idx] <= 1'b1;
            visit_cnt        <= visit_cnt + COUNT_W'(1);
            depth            <= depth + DW'(1);
            top_node         <= hit_node;
            top_scan         <= SCAN_W'(1);
            cur_row          <= row_q & ~(ONE_HOT << node_idx);
          end else begin
            cycle_seen <= 1'b1;
          end
          state <= S_SCAN;
        end

        S_POP: begin
          top_node <= stk_top.node;
          top_scan <= stk_top.scan;
          state    <= S_LOAD;
        end

        S_FINISH: begin
          if (out_free) begin
            visited_count <= visit_cnt;
            if (visit_cnt != n_eff) begin
              verdict <= VERDICT_SPLIT;
            end else if (cycle_seen) begin
              verdict <= VERDICT_CYCLE;
            end else begin
              verdict <= VERDICT_TREE;
            end
            // empty the graph for the next load
            row_valid  <= '0;
            visited    <= '0;
            cycle_seen <= 1'b0;
            depth      <= '0;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // stack never holds more entries than there are nodes
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(MAX_NODES))
    else $error("walk stack depth above node limit");

  // a scan step always has a node on the stack
  a_scan_has_top: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (depth != '0))
    else $error("scan with empty stack");

  // posting a result leaves the graph empty
  a_clear_on_post: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_free) |=>
      (out_valid && visited == '0 && row_valid == '0 && !cycle_seen))
    else $error("graph not cleared after result");

  // visit count never passes the node count during a walk
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_TAKE) |-> (visit_cnt <= n_eff))
    else $error("visited count above node count");

  // only defined verdict codes leave the block
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (verdict == VERDICT_TREE || verdict == VERDICT_SPLIT ||
                   verdict == VERDICT_CYCLE))
    else $error("undefined verdict code");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// checks the undirected tree check block: edges are loaded into a local copy
// of the adjacency matrix, every evaluate is judged by a local depth-first
// walk, and each verdict transfer is compared field by field in order
// ----------------------------------------------------------------------------
module tb_top;
  import utc_pkg::*;

  localparam int GRAPH_MAX    = 64;
  // an edge load still runs through the block's edge states after its transfer
  localparam int QUIET_CYCLES = 10;
  localparam logic [2:0] NODE_COUNT_ADDR = 3'(REG_NODE_COUNT) << 2;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [COUNT_W-1:0]   visited;
  } tree_report_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // input channel
  logic              in_valid    = 1'b0;
  logic              in_stall;
  logic              opcode      = OP_ADD_EDGE;
  logic [NODE_W-1:0] first_node  = '0;
  logic [NODE_W-1:0] second_node = '0;

  // result channel
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [VERDICT_W-1:0] verdict;
  logic [COUNT_W-1:0]   visited_count;

  // configuration port
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // local copy of the block state
  logic [GRAPH_MAX-1:0] adj_rows [GRAPH_MAX];
  logic [GRAPH_MAX-1:0] reached  = '0;
  logic                 loop_found = 1'b0;
  logic [NODE_W-1:0]    node_count_reg = NODE_W'(1);

  // verdicts predicted but not yet seen on the result channel
  tree_report_t pending_reports[$];

  int fail_count   = 0;
  int useful_items = 0;
  // idle rates in percent, changed per test phase
  int send_gap_pct = 0;
  int recv_gap_pct = 0;

  undirected_tree_check dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .first_node   (first_node),
    .second_node  (second_node),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .verdict      (verdict),
    .visited_count(visited_count),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk = ~clk;

  initial begin
    foreach (adj_rows[i]) adj_rows[i] = '0;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // counts above the matrix size saturate
  function automatic int live_nodes();
    return (node_count_reg > GRAPH_MAX) ? GRAPH_MAX : int'(node_count_reg);
  endfunction

  // returns whether the edge was stored; bad ends are dropped silently
  function automatic bit load_link(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b);
    int n;
    n = live_nodes();
    if (a < 1 || b < 1 || a > n || b > n) return 1'b0;
    adj_rows[a-1][b-1] = 1'b1;
    adj_rows[b-1][a-1] = 1'b1;
    return 1'b1;
  endfunction

  // depth-first walk from node 1; taking an edge clears its reverse copy,
  // and landing on a reached node (self-loops too) marks a cycle
  function automatic tree_report_t judge_graph();
    int n;
    int depth;
    int top;
    int at;
    int scan;
    int count;
    int stack_at   [GRAPH_MAX];
    int stack_scan [GRAPH_MAX];
    tree_report_t r;
    n = live_nodes();
    count = 0;
    depth = 0;
    if (n >= 1) begin
      reached[0] = 1'b1;
      stack_at[0] = 1;
      stack_scan[0] = 1;
      depth = 1;
      while (depth > 0) begin
        top  = depth - 1;
        at   = stack_at[top];
        scan = stack_scan[top];
        if (scan > n) begin
          depth--;
        end else begin
          stack_scan[top] = scan + 1;
          if (adj_rows[at-1][scan-1]) begin
            adj_rows[scan-1][at-1] = 1'b0;
            if (!reached[scan-1]) begin
              reached[scan-1] = 1'b1;
              if (depth < GRAPH_MAX) begin
                stack_at[depth] = scan;
                stack_scan[depth] = 1;
                depth++;
              end
            end else begin
              loop_found = 1'b1;
            end
          end
        end
      end
      for (int i = 0; i < n; i++) if (reached[i]) count++;
    end
    // a split graph wins over a cycle
    if (count != n) r.verdict = VERDICT_SPLIT;
    else if (loop_found) r.verdict = VERDICT_CYCLE;
    else r.verdict = VERDICT_TREE;
    r.visited = COUNT_W'(count);
    // graph is wiped after every evaluate
    foreach (adj_rows[i]) adj_rows[i] = '0;
    reached = '0;
    loop_found = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch in %s: got %0d, want %0d (t=%0t)", what, got, want, $time);
    fail_count++;
  endtask

  // random backpressure on the result channel
  always @(posedge clk) begin
    out_stall <= (recv_gap_pct > 0) && ($urandom_range(99) < recv_gap_pct);
  end

  // every result transfer is matched against the oldest prediction
  always @(posedge clk) begin
    tree_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch("result with no evaluate pending", int'(verdict), -1);
      end else begin
        want = pending_reports.pop_front();
        if (verdict !== want.verdict)
          flag_mismatch("verdict", int'(verdict), int'(want.verdict));
        if (visited_count !== want.visited)
          flag_mismatch("visited_count", int'(visited_count), int'(want.visited));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one input transfer; valid stays high into the next item unless a gap is drawn
  task automatic send_item(input logic op, input logic [NODE_W-1:0] a,
                           input logic [NODE_W-1:0] b);
    if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_gap_pct) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    first_node  <= a;
    second_node <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer happened at this edge
    if (op == OP_EVALUATE) begin
      pending_reports.push_back(judge_graph());
      useful_items++;
    end else if (load_link(a, b)) begin
      useful_items++;
    end
  endtask

  // stop sending until every verdict is back, then let edge loads settle
  task automatic hold_until_drained(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // write node_count while idle, then read it back
  task automatic program_node_count(input logic [NODE_W-1:0] value);
    hold_until_drained(QUIET_CYCLES);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NODE_COUNT_ADDR;
    pwdata  <= {{(32-NODE_W){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    node_count_reg = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[NODE_W-1:0] !== value)
      flag_mismatch("node_count readback", int'(prdata[NODE_W-1:0]), int'(value));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [NODE_W-1:0] pick_node_count();
    int roll;
    roll = $urandom_range(99);
    if (roll < 4)  return '0;
    if (roll < 9)  return NODE_W'(1);
    if (roll < 70) return NODE_W'($urandom_range(2, 10));
    if (roll < 88) return NODE_W'($urandom_range(11, 63));
    if (roll < 95) return NODE_W'(GRAPH_MAX);
    return NODE_W'($urandom_range(65, 127));
  endfunction

  function automatic logic [NODE_W-1:0] any_node();
    return NODE_W'($urandom_range(127));
  endfunction

  // a random spanning tree (or plain noise), often broken by a dropped or extra
  // edge, with occasional repeats and out-of-range noise, loaded in random order
  task automatic send_random_graph();
    logic [2*NODE_W-1:0] links[$];
    logic [NODE_W-1:0]   label [GRAPH_MAX];
    logic [NODE_W-1:0]   tmp_node;
    logic [2*NODE_W-1:0] tmp_link;
    int m;
    int j;
    int flavor;
    m = live_nodes();
    flavor = $urandom_range(99);
    if (flavor < 10 || m < 2) begin
      // plain noise, plus sometimes an in-range pair (self-loop on small graphs)
      repeat ($urandom_range(0, 6)) links.push_back({any_node(), any_node()});
      if (m >= 1 && $urandom_range(1) == 1)
        links.push_back({NODE_W'($urandom_range(1, m)), NODE_W'($urandom_range(1, m))});
    end else begin
      for (int i = 0; i < m; i++) label[i] = NODE_W'(i + 1);
      for (int i = m - 1; i > 0; i--) begin
        j = $urandom_range(i);
        tmp_node = label[i];
        label[i] = label[j];
        label[j] = tmp_node;
      end
      for (int v = 1; v < m; v++) begin
        j = $urandom_range(v - 1);
        links.push_back({label[v], label[j]});
      end
      // split the tree, or close a loop
      if (flavor < 35)
        links.delete($urandom_range(links.size() - 1));
      else if (flavor < 60)
        links.push_back({NODE_W'($urandom_range(1, m)), NODE_W'($urandom_range(1, m))});
      if (links.size() > 0 && $urandom_range(99) < 20)
        links.push_back(links[$urandom_range(links.size() - 1)]);
      if ($urandom_range(99) < 20)
        links.push_back({any_node(), any_node()});
    end
    for (int i = links.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp_link = links[i];
      links[i] = links[j];
      links[j] = tmp_link;
    end
    foreach (links[i]) begin
      if ($urandom_range(1) == 1)
        send_item(OP_ADD_EDGE, links[i][NODE_W-1:0], links[i][2*NODE_W-1:NODE_W]);
      else
        send_item(OP_ADD_EDGE, links[i][2*NODE_W-1:NODE_W], links[i][NODE_W-1:0]);
    end
    send_item(OP_EVALUATE, any_node(), any_node());
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // node count is 1 out of reset: lone node is a tree, a self-loop is a cycle
  task automatic test_reset_count();
    send_item(OP_EVALUATE, NODE_W'(127), NODE_W'(0));
    send_item(OP_ADD_EDGE, NODE_W'(1), NODE_W'(1));
    send_item(OP_ADD_EDGE, NODE_W'(1), NODE_W'(2));
    send_item(OP_EVALUATE, NODE_W'(0), NODE_W'(127));
  endtask

  // zero nodes skips the walk; an oversized count saturates to the matrix size
  task automatic test_count_limits();
    program_node_count('0);
    send_item(OP_ADD_EDGE, NODE_W'(1), NODE_W'(1));
    send_item(OP_EVALUATE, NODE_W'(0), NODE_W'(0));
    program_node_count(NODE_W'(127));
    send_item(OP_ADD_EDGE, NODE_W'(1), NODE_W'(64));
    send_item(OP_ADD_EDGE, NODE_W'(127), NODE_W'(64));
    send_item(OP_ADD_EDGE, NODE_W'(0), NODE_W'(5));
    send_item(OP_ADD_EDGE, NODE_W'(64), NODE_W'(64));
    send_item(OP_EVALUATE, NODE_W'(127), NODE_W'(127));
  endtask

  // a small tree with a repeated edge, then a small graph with a loop
  task automatic test_small_shapes();
    program_node_count(NODE_W'(4));
    send_item(OP_ADD_EDGE, NODE_W'(1), NODE_W'(2));
    send_item(OP_ADD_EDGE, NODE_W'(2), NODE_W'(3));
    send_item(OP_ADD_EDGE, NODE_W'(4), NODE_W'(2));
    send_item(OP_ADD_EDGE, NODE_W'(3), NODE_W'(2));
    send_item(OP_EVALUATE, NODE_W'(0), NODE_W'(0));
    send_item(OP_ADD_EDGE, NODE_W'(1), NODE_W'(2));
    send_item(OP_ADD_EDGE, NODE_W'(2), NODE_W'(3));
    send_item(OP_ADD_EDGE, NODE_W'(3), NODE_W'(1));
    send_item(OP_ADD_EDGE, NODE_W'(3), NODE_W'(4));
    send_item(OP_EVALUATE, NODE_W'(0), NODE_W'(0));
  endtask

  // shrink the count after loading: edges to higher nodes drop out of the walk
  task automatic test_count_shrink();
    send_item(OP_ADD_EDGE, NODE_W'(1), NODE_W'(2));
    send_item(OP_ADD_EDGE, NODE_W'(2), NODE_W'(3));
    send_item(OP_ADD_EDGE, NODE_W'(3), NODE_W'(4));
    program_node_count(NODE_W'(2));
    send_item(OP_EVALUATE, NODE_W'(0), NODE_W'(0));
  endtask

  // random graphs under one idle pattern; a new node count per batch of 1 to 3 graphs
  task automatic test_random_graphs(input int s_pct, input int r_pct, input int budget);
    int stop_at;
    send_gap_pct = s_pct;
    recv_gap_pct = r_pct;
    stop_at = useful_items + budget;
    while (useful_items < stop_at) begin
      program_node_count(pick_node_count());
      repeat ($urandom_range(1, 3)) begin
        if (useful_items < stop_at) send_random_graph();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_gap_pct = 12;
    recv_gap_pct = 85;
    test_reset_count();
    test_count_limits();
    test_small_shapes();
    test_count_shrink();
    test_random_graphs(12, 85, 160);
    test_random_graphs(85, 12, 160);
    test_random_graphs(0, 0, 160);
    // all sent; wait out the last verdicts and any edge still loading
    hold_until_drained(32);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // hard stop, far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
